// ===== src/lckm_pkg.sv =====
`default_nettype none

package lckm_pkg;

  localparam int unsigned LINES_DEFAULT       = 16;
  localparam int unsigned LINE_LENGTH_DEFAULT = 40;

  localparam int unsigned KEYWORDS   = 8;
  localparam int unsigned KW_IDX_W   = 3;
  localparam int unsigned KW_MAX_LEN = 22;
  localparam int unsigned KW_LEN_W   = 5;

  localparam logic [7:0] NEWLINE = 8'h0A;

  // ASCII text, right-aligned: the first character sits in the highest used byte.
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KEYWORDS] = '{
    (KW_MAX_LEN*8)'(80'h6c65645f616c6c5f6f6e),
    (KW_MAX_LEN*8)'(88'h6c65645f616c6c5f6f6666),
    (KW_MAX_LEN*8)'(128'h73686966745f6c6566745f6c65646f6e),
    (KW_MAX_LEN*8)'(136'h73686966745f72696768745f6c65646f6e),
    (KW_MAX_LEN*8)'(168'h73686966745f6c6566745f6b6565705f6c65646f6e),
    (KW_MAX_LEN*8)'(176'h73686966745f72696768745f6b6565705f6c65646f6e),
    (KW_MAX_LEN*8)'(72'h666c6f7765725f6f6e),
    (KW_MAX_LEN*8)'(80'h666c6f7765725f6f6666)
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KEYWORDS] = '{
    5'd10, 5'd11, 5'd16, 5'd17, 5'd21, 5'd22, 5'd9, 5'd10
  };

  typedef struct packed {
    logic                matched;
    logic [KW_IDX_W-1:0] index;
  } outcome_t;

  typedef struct packed {
    logic     valid;
    outcome_t outcome;
  } push_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [KW_IDX_W-1:0] mode;
    logic                matched;
  } out_item_t;

  // Character at position pos of keyword k; pos must be below that keyword's length.
  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                         input logic [KW_LEN_W-1:0] pos);
    logic [KW_MAX_LEN*8-1:0] text;
    logic [KW_LEN_W-1:0]     idx;
    text    = KW_TEXT[k];
    idx     = KW_LEN[k] - 5'd1 - pos;
    kw_char = text[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== src/lckm_stream_if.sv =====
`default_nettype none

interface lckm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/lckm_ram.sv =====
`default_nettype none

module lckm_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/lckm_line_match.sv =====
`default_nettype none

module lckm_line_match #(
  parameter int unsigned LINE_LENGTH = lckm_pkg::LINE_LENGTH_DEFAULT
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            byte_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  output lckm_pkg::push_t      push_o
);

  localparam int unsigned ColW = $clog2(LINE_LENGTH);

  logic [ColW-1:0]               column_q, column_d;
  logic [lckm_pkg::KEYWORDS-1:0] alive_q, alive_d;
  lckm_pkg::outcome_t            outcome;

  // At most one keyword survives to its full length, so order is irrelevant.
  always_comb begin
    outcome = '0;
    for (int k = 0; k < lckm_pkg::KEYWORDS; k++) begin
      if (alive_q[k] && column_q >= ColW'(lckm_pkg::KW_LEN[k])) begin
        outcome.matched = 1'b1;
        outcome.index   = lckm_pkg::KW_IDX_W'(k);
      end
    end
  end

  always_comb begin
    column_d       = column_q;
    alive_d        = alive_q;
    push_o.valid   = 1'b0;
    push_o.outcome = outcome;
    if (byte_valid_i) begin
      if (rx_byte_i == lckm_pkg::NEWLINE) begin
        push_o.valid = 1'b1;
        column_d     = '0;
        alive_d      = '1;
      end else if (column_q < ColW'(LINE_LENGTH - 1)) begin
        for (int k = 0; k < lckm_pkg::KEYWORDS; k++) begin
          if (column_q < ColW'(lckm_pkg::KW_LEN[k]) &&
              lckm_pkg::kw_char(lckm_pkg::KW_IDX_W'(k),
                                column_q[lckm_pkg::KW_LEN_W-1:0]) != rx_byte_i) begin
            alive_d[k] = 1'b0;
          end
        end
        column_d = column_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      alive_q  <= '1;
    end else begin
      column_q <= column_d;
      alive_q  <= alive_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lckm_ring.sv =====
`default_nettype none

module lckm_ring #(
  parameter int unsigned LINES = lckm_pkg::LINES_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  lckm_pkg::push_t         push_i,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output lckm_pkg::outcome_t      rd_outcome_o
);

  localparam int unsigned PtrW = $clog2(LINES);
  localparam int unsigned CntW = $clog2(LINES + 1);
  localparam int unsigned OutW = $bits(lckm_pkg::outcome_t);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full, do_push, do_pop;
  logic [OutW-1:0] rdata;

  assign empty_o = (count_q == '0);
  assign full    = (count_q == CntW'(LINES));
  // A line ending into a full ring is dropped; a take from an empty ring does nothing.
  assign do_push = push_i.valid && !full;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d  = (tail_q == PtrW'(LINES - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      head_d  = (head_q == PtrW'(LINES - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  lckm_ram #(
    .WIDTH (OutW),
    .DEPTH (LINES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (tail_q),
    .wdata_i (push_i.outcome),
    .re_i    (do_pop),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign rd_outcome_o = lckm_pkg::outcome_t'(rdata);

endmodule

`default_nettype wire

// ===== src/line_command_keyword_matcher.sv =====
`default_nettype none

// Line command keyword matcher. Items on in_i carry either a received byte
// (cmd = 0) or a take request (cmd = 1). Bytes are gathered into lines ended by
// newline; each line is checked byte by byte for a prefix match against eight
// fixed command keywords, and the finished line's outcome is stored in a ring of
// LINES entries (a line that ends while the ring is full is dropped, bytes past
// LINE_LENGTH-1 in a line are ignored). A take pops the oldest outcome and gives
// one item on out_o: the held mode (updated to the keyword index on a match)
// and the matched flag; a take from an empty ring gives nothing. One item is
// accepted every cycle unless stalled: an input register, the byte match logic
// or the ring's read port, the ring's registered read data, and an output
// register, which a take's result passes in turn. Input is stalled only when
// the output register and the read data stage are both held by back-pressure.
module line_command_keyword_matcher #(
  parameter int unsigned LINES       = lckm_pkg::LINES_DEFAULT,
  parameter int unsigned LINE_LENGTH = lckm_pkg::LINE_LENGTH_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lckm_stream_if.sink   in_i,
  lckm_stream_if.source out_o
);

  logic                          in_valid_q;
  lckm_pkg::in_item_t            in_item_q;
  logic                          rd_valid_q;
  logic                          out_valid_q;
  lckm_pkg::out_item_t           out_item_q;
  logic [lckm_pkg::KW_IDX_W-1:0] held_mode_q;

  logic               load_out, advance, take_req, ring_empty;
  lckm_pkg::push_t    push;
  lckm_pkg::outcome_t rd_outcome;

  assign load_out = rd_valid_q && (!out_valid_q || out_o.ready);
  assign advance  = !rd_valid_q || load_out;
  assign take_req = in_valid_q && advance && in_item_q.cmd;

  assign in_i.ready = !in_valid_q || advance;

  lckm_line_match #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_line_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_q && advance && !in_item_q.cmd),
    .rx_byte_i    (in_item_q.rx_byte),
    .push_o       (push)
  );

  lckm_ring #(
    .LINES (LINES)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (take_req),
    .empty_o      (ring_empty),
    .rd_outcome_o (rd_outcome)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_mode_q <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (take_req && !ring_empty) begin
        rd_valid_q <= 1'b1;
      end else if (load_out) begin
        rd_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (rd_outcome.matched) begin
          held_mode_q <= rd_outcome.index;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      in_item_q <= in_i.payload;
    end
    if (load_out) begin
      out_item_q.mode    <= rd_outcome.matched ? rd_outcome.index : held_mode_q;
      out_item_q.matched <= rd_outcome.matched;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

`default_nettype wire
